// ----- rtl/pts_pkg.sv -----
package pts_pkg;

  localparam int MAX_TASKS_DEF = 8;
  localparam int MAX_RESULTS   = 12;
  localparam int RES_CNT_W     = 4;

  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_IDLE    = 3'd1;
  localparam logic [2:0] EV_MISS    = 3'd2;
  localparam logic [2:0] EV_PREEMPT = 3'd3;
  localparam logic [2:0] EV_FINISH  = 3'd4;
  localparam logic [2:0] EV_RUNEND  = 3'd5;
  localparam logic [2:0] EV_FULL    = 3'd6;

  localparam logic POL_RM  = 1'b0;
  localparam logic POL_EDF = 1'b1;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_RUNLEN = 1'b1;

  typedef struct packed {
    logic        v;
    logic [2:0]  kind;
    logic [2:0]  id;
    logic [15:0] dur;
    logic [15:0] cnt;
  } emit_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

endpackage

// ----- rtl/pts_out.sv -----
module pts_out
  import pts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  emit_t       ev,
  input  logic        done,
  output logic        out_valid,
  output logic [2:0]  out_event_kind,
  output logic [2:0]  out_task_id,
  output logic [15:0] out_duration,
  output logic [15:0] out_event_count,
  output logic        out_last
);

  // one result is held back so the final one can carry last
  emit_t               hold_r;
  logic [RES_CNT_W-1:0] cnt_r;
  logic                valid_r, last_r;
  emit_t               data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r.v <= 1'b0;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      if (done) begin
        valid_r <= 1'b1;
        last_r  <= 1'b1;
        if (hold_r.v) begin
          data_r <= hold_r;
        end else begin
          data_r <= '{v: 1'b1, kind: EV_NONE, id: 3'd0, dur: 16'd0, cnt: 16'd0};
        end
        hold_r.v <= 1'b0;
        cnt_r    <= '0;
      end else if (ev.v && cnt_r < RES_CNT_W'(MAX_RESULTS)) begin
        valid_r <= hold_r.v;
        last_r  <= 1'b0;
        data_r  <= hold_r;
        hold_r  <= ev;
        cnt_r   <= cnt_r + RES_CNT_W'(1);
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_event_kind  = data_r.kind;
  assign out_task_id     = data_r.id;
  assign out_duration    = data_r.dur;
  assign out_event_count = data_r.cnt;
  assign out_last        = last_r;

endmodule

// ----- rtl/periodic_task_scheduler.sv -----
// channel   | transfer when             | payload
// input     | start && !busy            | in_mode, in_period, in_burst
// result    | out_valid (one cycle)     | out_event_kind, out_task_id, out_duration,
//           |                           | out_event_count, out_last
// config    | psel&penable&pwrite       | paddr, pwdata (prdata on read)
// an add goes from idle to the done state; a tick walks the loaded slots once per
// selection pass, one slot a cycle, then switches and, if a task runs, checks its
// finish; each completion starts a new pass, and the tick then ends, reports on the
// final tick of the run and closes in the done state.
// rst_n is synchronous; results are held back one deep so the final one carries out_last.
// the receiver cannot stall; busy falls in the cycle the final result is out.
module periodic_task_scheduler
  import pts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [15:0] in_period,
  input  logic [15:0] in_burst,
  output logic        out_valid,
  output logic [2:0]  out_event_kind,
  output logic [2:0]  out_task_id,
  output logic [15:0] out_duration,
  output logic [15:0] out_event_count,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W  = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int TL_W   = $clog2(MAX_TASKS + 1);
  localparam int ITER_W = $clog2(MAX_TASKS + 2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_SWITCH = 3'd2;
  localparam logic [2:0] S_FIN    = 3'd3;
  localparam logic [2:0] S_END    = 3'd4;
  localparam logic [2:0] S_REPT   = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [15:0] period_r   [MAX_TASKS];
  logic [15:0] burst_r    [MAX_TASKS];
  logic [16:0] rel_r      [MAX_TASKS];
  logic [15:0] rem_r      [MAX_TASKS];
  logic [15:0] seg_r      [MAX_TASKS];
  logic [15:0] miss_r     [MAX_TASKS];
  logic [15:0] fin_r      [MAX_TASKS];
  logic [15:0] kill_r     [MAX_TASKS];
  logic [MAX_TASKS-1:0] pend_r, due_r;

  logic              policy_r;
  logic [15:0]       run_len_r;
  logic [2:0]        state_r, state_nxt;
  logic [TL_W-1:0]   loaded_r;
  logic [15:0]       tick_r;
  logic              run_v_r;
  logic [IDX_W-1:0]  run_r;
  logic [15:0]       idle_since_r;
  logic              idle_flag_r;
  logic [IDX_W-1:0]  slot_r;
  logic [ITER_W-1:0] iter_r;
  logic              best_v_r;
  logic [IDX_W-1:0]  best_r;
  logic signed [17:0] best_key_r;

  emit_t ev;
  logic  done;

  logic              accept, cfg_wr;
  logic              full;
  logic [IDX_W-1:0]  add_idx;
  logic [15:0]       add_p;
  logic              rel_due, is_miss, pend_now, take;
  logic signed [17:0] diff, key;
  logic [16:0]       rel_now;
  logic              last_slot;
  logic              switching;
  logic [15:0]       pre_d, pre_rem, seg_eff;
  logic              fin_hit;
  logic              rep_run, rep_idle;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_RUNLEN) ? {16'd0, run_len_r} : {31'd0, policy_r};

  assign full    = (loaded_r == TL_W'(MAX_TASKS));
  assign add_idx = loaded_r[IDX_W-1:0];
  assign add_p   = (in_period == 16'd0) ? 16'd1 : in_period;

  // release check and key for the slot under the scan pointer
  assign diff = $signed({2'b00, tick_r}) - $signed({rel_r[slot_r][16], rel_r[slot_r]});
  assign rel_due  = (diff >= $signed({2'b00, period_r[slot_r]}));
  assign is_miss  = rel_due && run_v_r && (run_r == slot_r) && pend_r[slot_r];
  assign rel_now  = rel_due ? {1'b0, tick_r} : rel_r[slot_r];
  assign pend_now = pend_r[slot_r] || rel_due;
  assign key = (policy_r == POL_EDF)
             ? $signed({rel_now[16], rel_now}) + $signed({2'b00, period_r[slot_r]})
             : $signed({2'b00, period_r[slot_r]});
  assign take      = pend_now && (!best_v_r || key < best_key_r);
  assign last_slot = (TL_W'(slot_r) + TL_W'(1) == loaded_r);

  assign switching = (run_v_r != best_v_r) || (run_v_r && run_r != best_r);
  assign pre_d     = tick_r - seg_r[run_r];
  assign pre_rem   = (rem_r[run_r] > pre_d) ? rem_r[run_r] - pre_d : 16'd0;

  assign seg_eff = due_r[best_r] ? tick_r : seg_r[best_r];
  assign fin_hit = !((tick_r - seg_eff) < rem_r[best_r]);

  assign rep_run  = run_v_r && pend_r[run_r];
  assign rep_idle = !run_v_r && idle_flag_r && (tick_r > idle_since_r);

  always_comb begin
    ev   = '{v: 1'b0, kind: EV_NONE, id: 3'd0, dur: 16'd0, cnt: 16'd0};
    done = (state_r == S_DONE);
    case (state_r)
      S_IDLE: begin
        if (accept && in_mode && full) begin
          ev = '{v: 1'b1, kind: EV_FULL, id: 3'd0, dur: 16'd0, cnt: 16'd0};
        end
      end
      S_SCAN: begin
        if (is_miss) begin
          ev = '{v: 1'b1, kind: EV_MISS, id: 3'(slot_r), dur: tick_r - seg_r[slot_r],
                 cnt: sat_inc(miss_r[slot_r])};
        end
      end
      S_SWITCH: begin
        if (switching) begin
          if (!run_v_r) begin
            if (idle_flag_r && tick_r > idle_since_r) begin
              ev = '{v: 1'b1, kind: EV_IDLE, id: 3'd0, dur: tick_r - idle_since_r,
                     cnt: 16'd0};
            end
          end else if (pend_r[run_r]) begin
            ev = '{v: 1'b1, kind: EV_PREEMPT, id: 3'(run_r), dur: burst_r[run_r] - pre_rem,
                   cnt: 16'd0};
          end
        end
      end
      S_FIN: begin
        if (fin_hit) begin
          ev = '{v: 1'b1, kind: EV_FINISH, id: 3'(best_r), dur: rem_r[best_r],
                 cnt: sat_inc(fin_r[best_r])};
        end
      end
      S_REPT: begin
        if (rep_run) begin
          ev = '{v: 1'b1, kind: EV_RUNEND, id: 3'(run_r), dur: tick_r - seg_r[run_r],
                 cnt: sat_inc(kill_r[run_r])};
        end else if (rep_idle) begin
          ev = '{v: 1'b1, kind: EV_IDLE, id: 3'd0, dur: tick_r - idle_since_r, cnt: 16'd0};
        end
      end
      default: begin
        ev.v = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_mode || tick_r >= run_len_r) begin
            state_nxt = S_DONE;
          end else if (loaded_r == '0) begin
            state_nxt = S_SWITCH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN:   state_nxt = last_slot ? S_SWITCH : S_SCAN;
      S_SWITCH: state_nxt = best_v_r ? S_FIN : S_END;
      S_FIN: begin
        if (fin_hit && iter_r != ITER_W'(MAX_TASKS + 1)) begin
          state_nxt = (loaded_r == '0) ? S_SWITCH : S_SCAN;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END:    state_nxt = (tick_r + 16'd1 == run_len_r) ? S_REPT : S_DONE;
      S_REPT:   state_nxt = S_DONE;
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      policy_r     <= POL_EDF;
      run_len_r    <= 16'd1000;
      loaded_r     <= '0;
      tick_r       <= 16'd0;
      run_v_r      <= 1'b0;
      idle_since_r <= 16'd0;
      idle_flag_r  <= 1'b0;
      pend_r       <= '0;
      due_r        <= '0;
      best_v_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        if (paddr[2] == REG_POLICY) begin
          policy_r <= pwdata[0];
        end else begin
          run_len_r <= pwdata[15:0];
        end
      end
      case (state_r)
        S_IDLE: begin
          slot_r   <= '0;
          iter_r   <= '0;
          best_v_r <= 1'b0;
          if (accept && in_mode && !full) begin
            period_r[add_idx] <= add_p;
            burst_r[add_idx]  <= in_burst;
            rem_r[add_idx]    <= in_burst;
            rel_r[add_idx]    <= 17'd0 - {1'b0, add_p};
            pend_r[add_idx]   <= 1'b0;
            due_r[add_idx]    <= 1'b0;
            miss_r[add_idx]   <= 16'd0;
            fin_r[add_idx]    <= 16'd0;
            kill_r[add_idx]   <= 16'd0;
            loaded_r          <= loaded_r + TL_W'(1);
          end
        end
        S_SCAN: begin
          if (rel_due) begin
            if (is_miss) begin
              miss_r[slot_r] <= sat_inc(miss_r[slot_r]);
              kill_r[slot_r] <= sat_inc(kill_r[slot_r]);
            end
            pend_r[slot_r] <= 1'b1;
            rel_r[slot_r]  <= rel_now;
            due_r[slot_r]  <= 1'b1;
            rem_r[slot_r]  <= burst_r[slot_r];
          end
          if (take) begin
            best_v_r   <= 1'b1;
            best_r     <= slot_r;
            best_key_r <= key;
          end
          slot_r <= slot_r + IDX_W'(1);
        end
        S_SWITCH: begin
          if (switching) begin
            if (run_v_r && pend_r[run_r]) begin
              rem_r[run_r] <= pre_rem;
            end
            if (best_v_r) begin
              seg_r[best_r] <= tick_r;
              due_r[best_r] <= 1'b0;
              idle_flag_r   <= 1'b0;
            end else begin
              idle_flag_r  <= 1'b1;
              idle_since_r <= tick_r;
            end
            run_v_r <= best_v_r;
            run_r   <= best_r;
          end else if (!best_v_r) begin
            idle_flag_r <= 1'b1;
          end
        end
        S_FIN: begin
          due_r[best_r] <= 1'b0;
          seg_r[best_r] <= fin_hit ? tick_r : seg_eff;
          if (fin_hit) begin
            fin_r[best_r]  <= sat_inc(fin_r[best_r]);
            pend_r[best_r] <= 1'b0;
            run_v_r        <= 1'b0;
            idle_flag_r    <= 1'b1;
            idle_since_r   <= tick_r;
            iter_r         <= iter_r + ITER_W'(1);
            slot_r         <= '0;
            best_v_r       <= 1'b0;
          end
        end
        S_END: begin
          tick_r <= tick_r + 16'd1;
        end
        S_REPT: begin
          if (rep_run) begin
            kill_r[run_r] <= sat_inc(kill_r[run_r]);
          end
        end
        default: begin
          best_v_r <= 1'b0;
        end
      endcase
    end
  end

  pts_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .ev              (ev),
    .done            (done),
    .out_valid       (out_valid),
    .out_event_kind  (out_event_kind),
    .out_task_id     (out_task_id),
    .out_duration    (out_duration),
    .out_event_count (out_event_count),
    .out_last        (out_last)
  );

`ifndef SYNTHESIS
  a_last_on_release: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && out_last)
    else $error("busy dropped without final result");
  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");
  a_run_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    run_v_r |-> TL_W'(run_r) < loaded_r)
    else $error("running slot beyond loaded tasks");
`endif

endmodule

// ----- verif/tb.sv -----
module tb;
  import pts_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    logic [2:0]  id;
    logic [15:0] dur;
    logic [15:0] cnt;
    logic        last;
  } sched_event_t;

  // scoreboard: owns the scheduler prediction and the queue of pending events
  class sched_scoreboard;
    logic        pol;
    logic [15:0] run_len;
    logic [15:0] per_tab [8];
    logic [15:0] bur_tab [8];
    int          rel_t   [8];
    logic [15:0] remain  [8];
    bit          pend    [8];
    bit          due     [8];
    logic [15:0] seg_start [8];
    logic [15:0] misses  [8];
    logic [15:0] finishes[8];
    logic [15:0] kills   [8];
    int          loaded;
    logic [15:0] now;
    int          running;
    logic [15:0] idle_from;
    bit          idle_on;
    sched_event_t pending_events[$];
    sched_event_t batch[$];
    int errors;
    int n_checked;

    function void clear();
      pol = POL_EDF; run_len = 1000; loaded = 0; now = 0; running = -1;
      idle_from = 0; idle_on = 0; errors = 0; n_checked = 0;
      for (int i = 0; i < 8; i++) begin
        per_tab[i] = 0; bur_tab[i] = 0; rel_t[i] = 0; remain[i] = 0;
        pend[i] = 0; due[i] = 0; seg_start[i] = 0;
        misses[i] = 0; finishes[i] = 0; kills[i] = 0;
      end
    endfunction

    function void put(logic [2:0] k, int id, logic [15:0] d, logic [15:0] c);
      sched_event_t e;
      if (batch.size() >= MAX_RESULTS) return;
      e.kind = k; e.id = (id < 0) ? 3'd0 : id[2:0]; e.dur = d; e.cnt = c; e.last = 0;
      batch.push_back(e);
    endfunction

    function longint prio(int i);
      if (pol == POL_EDF) return longint'(rel_t[i]) + longint'(per_tab[i]);
      return longint'(per_tab[i]);
    endfunction

    function logic [15:0] inc16(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function void tick(logic [15:0] t);
      int best;
      int c;
      logic [15:0] d;
      for (int it = 0; it <= 9; it++) begin
        best = -1;
        for (int i = 0; i < loaded; i++) begin
          if (longint'(t) - longint'(rel_t[i]) >= longint'(per_tab[i])) begin
            if (running == i && pend[i]) begin
              misses[i] = inc16(misses[i]);
              kills[i] = inc16(kills[i]);
              put(EV_MISS, i, t - seg_start[i], misses[i]);
            end
            pend[i] = 1; rel_t[i] = t; due[i] = 1; remain[i] = bur_tab[i];
          end
          if (pend[i] && (best < 0 || prio(i) < prio(best))) best = i;
        end
        if (running != best) begin
          if (running < 0) begin
            if (idle_on && t > idle_from) put(EV_IDLE, -1, t - idle_from, 0);
          end else if (pend[running]) begin
            c = running;
            d = t - seg_start[c];
            remain[c] = (remain[c] > d) ? remain[c] - d : 16'd0;
            put(EV_PREEMPT, c, bur_tab[c] - remain[c], 0);
          end
          if (best >= 0) begin
            seg_start[best] = t; due[best] = 0; idle_on = 0;
          end else begin
            idle_on = 1; idle_from = t;
          end
          running = best;
        end
        if (best < 0) begin
          idle_on = 1; running = -1;
          return;
        end
        if (due[best]) begin
          seg_start[best] = t; due[best] = 0;
        end
        if (16'(t - seg_start[best]) < remain[best]) return;
        finishes[best] = inc16(finishes[best]);
        put(EV_FINISH, best, remain[best], finishes[best]);
        pend[best] = 0; seg_start[best] = t; running = -1; idle_on = 1; idle_from = t;
      end
    endfunction

    // note an accepted command and queue the events it should cause
    function void note_command(logic mode, logic [15:0] per, logic [15:0] bur);
      logic [15:0] p;
      batch.delete();
      if (mode) begin
        if (loaded >= 8) put(EV_FULL, -1, 0, 0);
        else begin
          p = (per == 0) ? 16'd1 : per;
          per_tab[loaded] = p; bur_tab[loaded] = bur; remain[loaded] = bur;
          rel_t[loaded] = -int'(p); pend[loaded] = 0; due[loaded] = 0;
          misses[loaded] = 0; finishes[loaded] = 0; kills[loaded] = 0;
          loaded++;
        end
      end else if (now < run_len) begin
        tick(now);
        now++;
        if (now == run_len) begin
          if (running >= 0 && pend[running]) begin
            kills[running] = inc16(kills[running]);
            put(EV_RUNEND, running, now - seg_start[running], kills[running]);
          end else if (running < 0 && idle_on && now > idle_from)
            put(EV_IDLE, -1, now - idle_from, 0);
        end
      end
      if (batch.size() == 0) put(EV_NONE, -1, 0, 0);
      batch[batch.size()-1].last = 1;
      foreach (batch[i]) pending_events.push_back(batch[i]);
    endfunction

    function void check_event(sched_event_t got);
      sched_event_t x;
      n_checked++;
      if (pending_events.size() == 0) begin
        $error("unexpected event kind %0d", got.kind);
        errors++;
        return;
      end
      x = pending_events.pop_front();
      if (got.kind !== x.kind) begin
        $error("event_kind: expected %0d actual %0d", x.kind, got.kind); errors++;
      end
      if (got.id !== x.id) begin
        $error("task_id: expected %0d actual %0d", x.id, got.id); errors++;
      end
      if (got.dur !== x.dur) begin
        $error("duration: expected %0d actual %0d", x.dur, got.dur); errors++;
      end
      if (got.cnt !== x.cnt) begin
        $error("event_count: expected %0d actual %0d", x.cnt, got.cnt); errors++;
      end
      if (got.last !== x.last) begin
        $error("last: expected %0d actual %0d", x.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_mode = 0;
  logic [15:0] in_period = 0;
  logic [15:0] in_burst = 0;
  logic        out_valid;
  logic [2:0]  out_event_kind;
  logic [2:0]  out_task_id;
  logic [15:0] out_duration;
  logic [15:0] out_event_count;
  logic        out_last;
  logic        psel = 0, penable = 0, pwrite = 0;
  logic [2:0]  paddr = 0;
  logic [31:0] pwdata = 0;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sb = new();
  int idle_pct = 0;
  int n_cmds = 0;

  periodic_task_scheduler dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    sched_event_t e;
    if (rst_n && out_valid) begin
      e.kind = out_event_kind; e.id = out_task_id; e.dur = out_duration;
      e.cnt = out_event_count; e.last = out_last;
      sb.check_event(e);
    end
  end

  // start is left high after a transfer; busy blocks it until the next command
  task automatic send_cmd(logic mode, logic [15:0] per, logic [15:0] bur);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1; in_mode <= mode; in_period <= per; in_burst <= bur;
    do @(posedge clk); while (busy);
    sb.note_command(mode, per, bur);
    n_cmds++;
  endtask

  task automatic wait_drained();
    start <= 0;
    while (sb.pending_events.size() != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (addr == 3'd0) sb.pol = val[0];
    else sb.run_len = val[15:0];
  endtask

  // one phase: fresh policy and run length, a task set, then ticks
  task automatic run_phase(logic p, logic [15:0] rl, int n_ticks, int n_tasks);
    wait_drained();
    write_reg(3'd0, {31'd0, p});
    write_reg(3'd4, {16'd0, rl});
    for (int i = 0; i < n_tasks; i++)
      send_cmd(1, 16'($urandom_range(1, 24)), 16'($urandom_range(0, 6)));
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(99) < 4)
        send_cmd(1, 16'($urandom_range(0, 30)), 16'($urandom_range(0, 8)));
      else
        send_cmd(0, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, zero period, zero burst, table full, run over
    send_cmd(0, 0, 0);
    send_cmd(1, 16'd0, 16'd0);
    send_cmd(1, 16'hFFFF, 16'hFFFF);
    send_cmd(1, 16'd3, 16'd1);
    send_cmd(1, 16'd5, 16'd2);
    send_cmd(1, 16'd2, 16'd1);
    send_cmd(1, 16'hAAAA, 16'h5555);
    send_cmd(1, 16'h5555, 16'hAAAA);
    send_cmd(1, 16'd7, 16'd3);
    send_cmd(1, 16'd4, 16'd4);
    for (int i = 0; i < 8; i++) send_cmd(0, 16'hFFFF, 16'hFFFF);
    wait_drained();
    write_reg(3'd4, 32'd3);     // lowered below the tick count: no final report
    send_cmd(0, 0, 0);
    send_cmd(0, 0, 0);
    wait_drained();
    write_reg(3'd4, 32'd20);    // raised again, the run ends at tick 20
    write_reg(3'd0, 32'd0);
    for (int i = 0; i < 13; i++) send_cmd(0, 0, 0);
    // tick counter does not reset, so phases extend the run length
    wait_drained();
    write_reg(3'd4, 32'd65535);
    idle_pct = 0;  send_cmd(0, 0, 0);
    // new tasks cannot be added once the table is full, so vary policy only
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 86 : ((ph == 2) ? 25 : 0);
      run_phase(ph[0], 16'hFFFF, 50, 0);
    end
    idle_pct = 0;
    run_phase(1, 16'd1, 5, 0);
    $display("covered %0d commands and %0d events, both policies, table full",
             n_cmds, sb.n_checked);
    wait_drained();
    if (sb.errors == 0 && sb.pending_events.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("FAIL");
    $finish;
  end
endmodule
